@@ rtl/core/mqef_pkg.sv @@
package mqef_pkg;

  // Default sizing of the queue set.
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_BATCH_DEF   = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;

  // Request codes carried on in_tuser.
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_TAKE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Result status codes carried on out_tuser.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_BADTYPE = 3'd2;
  localparam logic [2:0] ST_NOQUEUE = 3'd3;
  localparam logic [2:0] ST_NOTHING = 3'd4;

  // Configuration register indexes.
  localparam logic REG_TYPE_MAP = 1'b0;
  localparam logic REG_ACTIVE   = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_SCAN,
    S_READ,
    S_EMIT,
    S_QUERY,
    S_BAD
  } mqef_state_t;

endpackage

@@ rtl/core/mqef_ram.sv @@
module mqef_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/multi_queue_event_fifo.sv @@
// Multi-queue event FIFO.
// A set of ring queues of 64-bit event words, each queue tagged io or task.
// Requests arrive on the in_ stream (kind on in_tuser): a put stores one
// word into a queue, a take drains up to max_count words from the lowest
// numbered non-empty queue whose type the mask allows, a query reports
// whether every active queue is empty. Each request yields one result
// transaction on the out_ stream, except a take that yields one per event;
// tlast marks the final result of a request and out_tuser holds the status.
// The cfg_ port writes the queue type map and the active queue count; write
// it only while no request is in flight.
// Timing: one request at a time. A put or an unknown request passes through
// S_PUT or S_BAD, which loads its result into the output register; the block
// is ready again in the same cycle that the result appears. A take scans
// queues one per cycle through the shared pointer compare unit, then reads
// each event from the event memory in S_READ and hands it out in S_EMIT. A
// query scans the active queues the same way until it finds a non-empty one.
// A result waits in the output register while out_tready is low; the
// sequencer holds until that register frees and accepts nothing meanwhile,
// but once idle it takes the next request even while the last result waits.
// Reset empties every queue and clears both configuration registers at once.
module multi_queue_event_fifo #(
  parameter int NUM_QUEUES  = mqef_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqef_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_BATCH   = mqef_pkg::MAX_BATCH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // queue_id[2:0], event_type[4:3], event_word[68:5], kind_mask[70:69],
  // max_count[75:71], zero padding above
  input  logic [mqef_pkg::IN_TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]                       in_tuser,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // event_out[63:0], source_queue[66:64], all_empty[67], zero padding above
  output logic [mqef_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [2:0]                       out_tuser,
  output logic                             out_tlast,
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [7:0]                       cfg_data
);

  import mqef_pkg::*;

  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QCW = $clog2(NUM_QUEUES + 1);
  localparam int PW  = $clog2(2 * QUEUE_DEPTH);
  localparam int CW  = $clog2(MAX_BATCH + 1);
  localparam int AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int NW0 = (PW > CW) ? PW : CW;
  localparam int NW  = (NW0 > 5) ? NW0 : 5;
  localparam logic [PW-1:0] DEPTH_V    = PW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_MOD_V  = PW'(2 * QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST_V = PW'(2 * QUEUE_DEPTH - 1);

  mqef_state_t state_r, state_nxt;

  // Request fields held for the duration of the request.
  logic [2:0]  qid_r;
  logic [1:0]  etype_r;
  logic [63:0] word_r;
  logic [1:0]  mask_r;
  logic [4:0]  maxc_r;

  // Configuration registers.
  logic [7:0] map_r;
  logic [3:0] active_r;

  // Queue cursor and remaining batch count.
  logic [QCW-1:0] q_r, q_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  // Ring pointers, counting modulo twice the depth.
  logic [PW-1:0] wptr_r [NUM_QUEUES];
  logic [PW-1:0] rptr_r [NUM_QUEUES];

  // Output register.
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [63:0] out_event_r;
  logic [2:0]  out_src_r;
  logic        out_last_r;
  logic        out_empty_r;

  logic        out_free;
  logic        out_load;
  logic [2:0]  ld_status;
  logic [63:0] ld_event;
  logic [2:0]  ld_src;
  logic        ld_last;
  logic        ld_empty;

  logic          wr_en;
  logic          rd_en;
  logic [63:0]   rd_data;
  logic [QW-1:0] qi;
  logic [QCW-1:0] live;
  logic [QCW+2:0] qx;
  logic          kind;
  logic [PW-1:0] cur_w, cur_r, fill, wslot, rslot;
  logic [AW-1:0] waddr, raddr;
  logic [2:0]    put_status;
  logic [4:0]    maxc_eff;
  logic [NW-1:0] capped, take_n;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Effective queue count, capped at the number of queues built.
  assign live = (32'(active_r) > NUM_QUEUES) ? QCW'(NUM_QUEUES) : QCW'(active_r);

  // Shared pointer unit: everything below looks at the queue under the cursor.
  assign qi    = q_r[QW-1:0];
  assign qx    = (QCW+3)'(q_r);
  assign kind  = (qx < (QCW+3)'(8)) ? map_r[qx[2:0]] : 1'b0;
  assign cur_w = wptr_r[qi];
  assign cur_r = rptr_r[qi];
  assign fill  = (cur_w >= cur_r) ? (cur_w - cur_r) : (cur_w - cur_r + PTR_MOD_V);
  assign wslot = (cur_w >= DEPTH_V) ? (cur_w - DEPTH_V) : cur_w;
  assign rslot = (cur_r >= DEPTH_V) ? (cur_r - DEPTH_V) : cur_r;
  assign waddr = AW'(int'(qi) * QUEUE_DEPTH + int'(wslot));
  assign raddr = AW'(int'(qi) * QUEUE_DEPTH + int'(rslot));

  // Put checks in priority order.
  always_comb begin
    if (etype_r > 2'd1) begin
      put_status = ST_BADTYPE;
    end else if (32'(qid_r) >= 32'(live)) begin
      put_status = ST_NOQUEUE;
    end else if (kind != etype_r[0]) begin
      put_status = ST_BADTYPE;
    end else if (fill >= DEPTH_V) begin
      put_status = ST_FULL;
    end else begin
      put_status = ST_OK;
    end
  end

  // Batch size: at least one, at most MAX_BATCH and at most what is stored.
  assign maxc_eff = (maxc_r == 5'd0) ? 5'd1 : maxc_r;
  assign capped   = (NW'(maxc_eff) > NW'(MAX_BATCH)) ? NW'(MAX_BATCH) : NW'(maxc_eff);
  assign take_n   = (capped > NW'(fill)) ? NW'(fill) : capped;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      q_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequencer next state and strobes.
  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    out_load  = 1'b0;
    ld_status = ST_OK;
    ld_event  = '0;
    ld_src    = '0;
    ld_last   = 1'b1;
    ld_empty  = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          q_nxt = '0;
          case (in_tuser)
            REQ_PUT: begin
              q_nxt     = QCW'(in_tdata[2:0]);
              state_nxt = S_PUT;
            end
            REQ_TAKE:  state_nxt = S_SCAN;
            REQ_QUERY: state_nxt = S_QUERY;
            default:   state_nxt = S_BAD;
          endcase
        end
      end
      S_PUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = put_status;
          ld_src    = qid_r;
          wr_en     = (put_status == ST_OK);
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (q_r >= live) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_status = ST_NOTHING;
            state_nxt = S_IDLE;
          end
        end else if (mask_r[kind] && (fill != '0)) begin
          cnt_nxt   = CW'(take_n);
          state_nxt = S_READ;
        end else begin
          q_nxt = q_r + 1'b1;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_event  = rd_data;
          ld_src    = 3'(q_r);
          ld_last   = (cnt_r == '0);
          state_nxt = (cnt_r == '0) ? S_IDLE : S_READ;
        end
      end
      S_QUERY: begin
        if ((q_r >= live) || (fill != '0)) begin
          if (out_free) begin
            out_load  = 1'b1;
            ld_empty  = (q_r >= live);
            state_nxt = S_IDLE;
          end
        end else begin
          q_nxt = q_r + 1'b1;
        end
      end
      S_BAD: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = ST_BADTYPE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Capture the request fields on each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      qid_r   <= in_tdata[2:0];
      etype_r <= in_tdata[4:3];
      word_r  <= in_tdata[68:5];
      mask_r  <= in_tdata[70:69];
      maxc_r  <= in_tdata[75:71];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r    <= '0;
      active_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TYPE_MAP: map_r    <= cfg_data;
        REG_ACTIVE:   active_r <= cfg_data[3:0];
        default:      ;
      endcase
    end
  end

  // Ring pointer updates for the queue under the cursor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wptr_r[i] <= '0;
        rptr_r[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        wptr_r[qi] <= (cur_w == PTR_LAST_V) ? '0 : cur_w + 1'b1;
      end
      if (rd_en) begin
        rptr_r[qi] <= (cur_r == PTR_LAST_V) ? '0 : cur_r + 1'b1;
      end
    end
  end

  // Event storage.
  mqef_ram #(
    .WIDTH (64),
    .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (waddr),
    .wr_data (word_r),
    .rd_en   (rd_en),
    .rd_addr (raddr),
    .rd_data (rd_data)
  );

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= ld_status;
      out_event_r  <= ld_event;
      out_src_r    <= ld_src;
      out_last_r   <= ld_last;
      out_empty_r  <= ld_empty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_empty_r, out_src_r, out_event_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/core/mqef_checker.sv @@
module mqef_port_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mqef_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]                       out_tuser,
  input logic                             out_tlast
);

  import mqef_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // One request at a time: the block is busy right after accepting one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted back to back");

  // Error and empty results carry no event word and close the request.
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tlast && (out_tdata[63:0] == 64'd0))
    else $error("error result with event data or without last");

  // An all-empty answer is a successful single-result query.
  a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67] |->
      out_tlast && (out_tuser == ST_OK) && (out_tdata[63:0] == 64'd0))
    else $error("all-empty flag on a result that is not a query answer");

  // No status code beyond the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_FULL) ||
                   (out_tuser == ST_BADTYPE) || (out_tuser == ST_NOQUEUE) ||
                   (out_tuser == ST_NOTHING))
    else $error("undefined result status");

endmodule

bind multi_queue_event_fifo mqef_port_checker u_mqef_port_checker (.*);

@@ verif/mqef_checker.sv @@
`timescale 1ns / 100ps

// Scoreboard for the multi-queue event FIFO. It watches the request, result and
// register channels, predicts every result transaction and compares them in order.
module mqef_checker
  import mqef_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [2:0]             out_tuser,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     requests_seen,
  output int                     results_seen
);

  localparam int NQ      = NUM_QUEUES_DEF;
  localparam int QD      = QUEUE_DEPTH_DEF;
  localparam int MB      = MAX_BATCH_DEF;
  localparam int PTR_MOD = 2 * QD;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] word;
    logic [2:0]  src;
    logic        last;
    logic        empty;
  } result_t;

  // Predicted block state.
  result_t     expected_results[$];
  int          wr_ptr[NQ];
  int          rd_ptr[NQ];
  logic [63:0] event_mem[NQ*QD];
  logic [7:0]  type_map;
  logic [3:0]  active_cnt;

  function automatic int queue_fill(int q);
    return (wr_ptr[q] + PTR_MOD - rd_ptr[q]) % PTR_MOD;
  endfunction

  task automatic push_result(logic [2:0] status, logic [63:0] word, logic [2:0] src,
                             logic last, logic empty);
    result_t r;
    r.status = status;
    r.word   = word;
    r.src    = src;
    r.last   = last;
    r.empty  = empty;
    expected_results.push_back(r);
  endtask

  // Works out the result transactions of one request and updates the state.
  task automatic predict_request(logic [1:0] req, logic [2:0] qid, logic [1:0] etype,
                                 logic [63:0] word, logic [1:0] mask, logic [4:0] maxc);
    int         live;
    int         q;
    int         n;
    int         k;
    logic [2:0] st;
    logic       empty;
    live = (active_cnt > NQ) ? NQ : active_cnt;
    case (req)
      REQ_PUT: begin
        if (etype > 2'd1) st = ST_BADTYPE;
        else if (qid >= live) st = ST_NOQUEUE;
        else if (type_map[qid] != etype[0]) st = ST_BADTYPE;
        else if (queue_fill(qid) >= QD) st = ST_FULL;
        else begin
          event_mem[qid*QD + wr_ptr[qid] % QD] = word;
          wr_ptr[qid] = (wr_ptr[qid] + 1) % PTR_MOD;
          st = ST_OK;
        end
        push_result(st, '0, qid, 1'b1, 1'b0);
      end
      REQ_TAKE: begin
        // Lowest-numbered non-empty queue whose type the mask allows.
        q = 0;
        while (q < live && !(mask[type_map[q]] && queue_fill(q) != 0)) q++;
        if (q >= live) begin
          push_result(ST_NOTHING, '0, 3'd0, 1'b1, 1'b0);
        end else begin
          n = (maxc == 0) ? 1 : maxc;
          if (n > MB) n = MB;
          if (n > queue_fill(q)) n = queue_fill(q);
          for (k = 0; k < n; k++) begin
            push_result(ST_OK, event_mem[q*QD + rd_ptr[q] % QD], 3'(q), k == n - 1, 1'b0);
            rd_ptr[q] = (rd_ptr[q] + 1) % PTR_MOD;
          end
        end
      end
      REQ_QUERY: begin
        empty = 1'b1;
        for (q = 0; q < live; q++) begin
          if (queue_fill(q) != 0) empty = 1'b0;
        end
        push_result(ST_OK, '0, 3'd0, 1'b1, empty);
      end
      default: begin
        push_result(ST_BADTYPE, '0, 3'd0, 1'b1, 1'b0);
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (!rst_n) begin
      expected_results.delete();
      for (int q = 0; q < NQ; q++) begin
        wr_ptr[q] = 0;
        rd_ptr[q] = 0;
      end
      for (int i = 0; i < NQ*QD; i++) event_mem[i] = '0;
      type_map      = '0;
      active_cnt    = '0;
      fail_count    = 0;
      requests_seen = 0;
      results_seen  = 0;
    end else begin
      // Compare each result transaction with the oldest prediction.
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.status = out_tuser;
        got.word   = out_tdata[63:0];
        got.src    = out_tdata[66:64];
        got.last   = out_tlast;
        got.empty  = out_tdata[67];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result: status %0d word %h queue %0d last %b empty %b",
                     $realtime, got.status, got.word, got.src, got.last, got.empty);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: expected status %0d word %h queue %0d last %b empty %b",
                       $realtime, exp_r.status, exp_r.word, exp_r.src, exp_r.last, exp_r.empty);
              $display("%0t:           got      status %0d word %h queue %0d last %b empty %b",
                       $realtime, got.status, got.word, got.src, got.last, got.empty);
            end
          end
        end
      end
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TYPE_MAP) type_map = cfg_data;
        else active_cnt = cfg_data[3:0];
      end
      // Accepted requests.
      if (in_tvalid && in_tready) begin
        requests_seen++;
        predict_request(in_tuser, in_tdata[2:0], in_tdata[4:3], in_tdata[68:5],
                        in_tdata[70:69], in_tdata[75:71]);
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ verif/tb_multi_queue_event_fifo.sv @@
`timescale 1ns / 100ps

module tb_multi_queue_event_fifo;
  import mqef_pkg::*;

  // Request code the block does not know.
  localparam logic [1:0] REQ_BOGUS = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_index;
  logic [7:0]             cfg_data;

  int         fail_count;
  int         pending;
  int         requests_seen;
  int         results_seen;
  int         hold_cycles = 0;
  bit         steady = 1'b0;
  int         settings_done = 0;
  logic [7:0] cur_type_map = '0;
  logic [3:0] cur_active = '0;

  multi_queue_event_fifo u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mqef_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("tb_multi_queue_event_fifo NOT OK");
    $finish;
  end

  // Result receiver: random back-pressure, a steady stretch, and long hold-offs on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else if (steady) begin
        out_tready = 1'b1;
      end else begin
        out_tready = ($urandom_range(99) >= 13);
      end
    end
  end

  // Offers one request and waits for its transaction; returns at the next falling edge.
  task automatic send_request(logic [1:0] req, logic [2:0] qid, logic [1:0] etype,
                              logic [63:0] word, logic [1:0] mask, logic [4:0] maxc);
    while (!steady && $urandom_range(99) < 13) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser        = req;
    in_tdata        = '0;
    in_tdata[2:0]   = qid;
    in_tdata[4:3]   = etype;
    in_tdata[68:5]  = word;
    in_tdata[70:69] = mask;
    in_tdata[75:71] = maxc;
    in_tvalid       = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Sender pause until every predicted result has been received.
  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [7:0] value);
    in_tvalid = 1'b0;
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_TYPE_MAP) cur_type_map = value;
    else cur_active = value[3:0];
  endtask

  // Mostly well-formed puts and takes against the live queues, with some noise.
  task automatic random_request(int put_pct);
    int          roll;
    int          span;
    int          live;
    int          q;
    logic [63:0] word;
    logic [1:0]  mask;
    logic [4:0]  maxc;
    live = (cur_active > 8) ? 8 : cur_active;
    roll = $urandom_range(99);
    span = 100 - put_pct;
    word = {$urandom, $urandom};
    if (roll < put_pct && live > 0) begin
      q = $urandom_range(live - 1);
      send_request(REQ_PUT, 3'(q), {1'b0, cur_type_map[q]}, word,
                   2'($urandom), 5'($urandom));
    end else if (roll < put_pct + span * 70 / 100) begin
      mask = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
      maxc = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
      send_request(REQ_TAKE, 3'($urandom), 2'($urandom), word, mask, maxc);
    end else if (roll < put_pct + span * 82 / 100) begin
      send_request(REQ_QUERY, 3'($urandom), 2'($urandom), word, 2'($urandom), 5'($urandom));
    end else begin
      send_request(2'($urandom), 3'($urandom), 2'($urandom), word,
                   2'($urandom), 5'($urandom));
    end
  endtask

  // Drains, writes both registers, then runs a batch of random requests.
  task automatic run_setting(logic [7:0] type_map, logic [3:0] active, int count,
                             int put_pct, int hold);
    wait_for_results();
    write_register(REG_TYPE_MAP, type_map);
    write_register(REG_ACTIVE, {4'($urandom), active});
    settings_done++;
    hold_cycles = hold;
    repeat (count) random_request(put_pct);
  endtask

  initial begin
    int guard;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_PUT;
    cfg_valid = 1'b0;
    cfg_index = REG_TYPE_MAP;
    cfg_data  = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: no queue exists.
    send_request(REQ_QUERY, 3'd0, 2'd0, '0, 2'd0, 5'd1);
    send_request(REQ_PUT, 3'd0, 2'd0, '1, 2'd0, 5'd1);
    send_request(REQ_TAKE, 3'd0, 2'd0, '0, 2'b11, 5'd16);

    // Queue 0 io, queue 1 task.
    wait_for_results();
    write_register(REG_TYPE_MAP, 8'h02);
    write_register(REG_ACTIVE, 8'h02);
    settings_done++;
    send_request(REQ_PUT, 3'd0, 2'd0, '1, 2'd0, 5'd0);
    send_request(REQ_PUT, 3'd0, 2'd0, 64'h8000_0000_0000_0001, 2'd0, 5'd0);
    // Type mismatch, invalid types, queues that do not exist.
    send_request(REQ_PUT, 3'd0, 2'd1, 64'h1234, 2'd0, 5'd0);
    send_request(REQ_PUT, 3'd0, 2'd3, 64'h1234, 2'd0, 5'd0);
    send_request(REQ_PUT, 3'd1, 2'd2, 64'h1234, 2'd0, 5'd0);
    send_request(REQ_PUT, 3'd2, 2'd0, 64'h1234, 2'd0, 5'd0);
    send_request(REQ_PUT, 3'd7, 2'd1, 64'h1234, 2'd0, 5'd0);
    send_request(REQ_PUT, 3'd1, 2'd1, '0, 2'd0, 5'd0);
    send_request(REQ_PUT, 3'd1, 2'd1, 64'h5555_5555_aaaa_aaaa, 2'd0, 5'd0);
    send_request(REQ_QUERY, 3'd0, 2'd0, '0, 2'd0, 5'd0);
    // Empty mask, zero count, oversized count, short batch.
    send_request(REQ_TAKE, 3'd0, 2'd0, '0, 2'b00, 5'd4);
    send_request(REQ_TAKE, 3'd0, 2'd0, '0, 2'b10, 5'd0);
    send_request(REQ_TAKE, 3'd0, 2'd0, '0, 2'b11, 5'd31);
    send_request(REQ_TAKE, 3'd0, 2'd0, '0, 2'b01, 5'd1);
    send_request(REQ_BOGUS, 3'd7, 2'd3, '1, 2'b11, 5'd31);
    send_request(REQ_TAKE, 3'd0, 2'd0, '0, 2'b10, 5'd16);
    send_request(REQ_QUERY, 3'd0, 2'd0, '0, 2'd0, 5'd0);

    // Random phases over several register settings.
    run_setting(8'h00, 4'd8, 50, 60, 0);
    steady = 1'b1;
    run_setting(8'hFF, 4'd8, 50, 55, 0);
    steady = 1'b0;
    // One queue, mostly puts: fills up while the receiver holds off.
    run_setting(8'hA5, 4'd1, 40, 88, 300);
    run_setting(8'h3C, 4'd15, 50, 50, 0);
    // Fewer active queues; the hidden ones keep their events.
    run_setting(8'($urandom), 4'd3, 40, 45, 0);
    run_setting(8'($urandom), 4'($urandom_range(8, 1)), 25, 40, 0);
    wait_for_results();
    repeat (25) random_request(40);
    run_setting(8'h00, 4'd0, 10, 50, 0);
    run_setting(8'hFF, 4'd8, 30, 20, 0);

    // Let the last results drain.
    in_tvalid = 1'b0;
    for (guard = 0; guard < 20000 && pending != 0; guard++) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("Ran %0d requests giving %0d result transactions over %0d register settings.",
             requests_seen, results_seen, settings_done);
    $display("Covered puts, takes, queries, unknown requests, full queues and long stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_multi_queue_event_fifo OK");
    end else begin
      $display("tb_multi_queue_event_fifo NOT OK");
    end
    $finish;
  end

endmodule
